[hdl/idle_valve_duty_stepper_unit_assert.svh]
// Assertion macros shared by the idle valve duty stepper RTL.
`ifndef IDLE_VALVE_DUTY_STEPPER_UNIT_ASSERT_SVH
`define IDLE_VALVE_DUTY_STEPPER_UNIT_ASSERT_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define IVDS_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define IVDS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/ivds_pkg.sv]
// Package with word types, register indexes, reason codes and constants of the duty stepper.
package ivds_pkg;

  localparam int RPM_W    = 14;
  localparam int TIME_W   = 32;
  localparam int POS_W    = 10;
  localparam int DUTY_W   = 10;
  localparam int REASON_W = 4;
  localparam int TARGET_W = 13;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 13;

  // Duty with sign and headroom for an add or subtract of a step.
  localparam int DUTY_EXT_W = DUTY_W + 2;

  // Band edges: floor(target * k / 100) as target * (k * RECIP) >> RECIP_SHIFT,
  // with RECIP = ceil(2^RECIP_SHIFT / 100). Exact for all 13-bit targets.
  localparam int RECIP_SHIFT = 27;
  localparam int MULT_W      = 28;
  localparam int PROD_W      = TARGET_W + MULT_W;
  localparam logic [MULT_W-1:0] LEFT_MULT  = MULT_W'(93 * 1342178);
  localparam logic [MULT_W-1:0] RIGHT_MULT = MULT_W'(107 * 1342178);

  localparam logic [DUTY_W-1:0] DEFAULT_DUTY = DUTY_W'(600);
  localparam logic [TIME_W-1:0] SETTLE_MS    = TIME_W'(1000);
  localparam logic [POS_W-1:0]  LOCKOUT_POS  = POS_W'(50);
  localparam logic [RPM_W:0]    MARGIN_RPM   = (RPM_W + 1)'(100);

  // Reset values of the configuration registers.
  localparam logic [RPM_W-1:0]  LEFT_RST       = RPM_W'(930);
  localparam logic [RPM_W-1:0]  RIGHT_RST      = RPM_W'(1070);
  localparam logic [DUTY_W-1:0] MIN_DUTY_RST   = DUTY_W'(100);
  localparam logic [DUTY_W-1:0] MAX_DUTY_RST   = DUTY_W'(900);
  localparam logic [DUTY_W-1:0] BIG_STEP_RST   = DUTY_W'(20);
  localparam logic [DUTY_W-1:0] SMALL_STEP_RST = DUTY_W'(5);

  localparam logic [CFG_INDEX_W-1:0] CFG_TARGET_RPM          = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] CFG_MIN_DUTY            = CFG_INDEX_W'(1);
  localparam logic [CFG_INDEX_W-1:0] CFG_MAX_DUTY            = CFG_INDEX_W'(2);
  localparam logic [CFG_INDEX_W-1:0] CFG_BIG_DECREASE_STEP   = CFG_INDEX_W'(3);
  localparam logic [CFG_INDEX_W-1:0] CFG_SMALL_DECREASE_STEP = CFG_INDEX_W'(4);
  localparam logic [CFG_INDEX_W-1:0] CFG_BIG_INCREASE_STEP   = CFG_INDEX_W'(5);
  localparam logic [CFG_INDEX_W-1:0] CFG_SMALL_INCREASE_STEP = CFG_INDEX_W'(6);

  localparam logic [REASON_W-1:0] RSN_STOP_CRANK = REASON_W'(0);
  localparam logic [REASON_W-1:0] RSN_FAR_LOW    = REASON_W'(1);
  localparam logic [REASON_W-1:0] RSN_SETTLING   = REASON_W'(2);
  localparam logic [REASON_W-1:0] RSN_IN_BAND    = REASON_W'(3);
  localparam logic [REASON_W-1:0] RSN_LOCKOUT    = REASON_W'(4);
  localparam logic [REASON_W-1:0] RSN_BIG_DOWN   = REASON_W'(5);
  localparam logic [REASON_W-1:0] RSN_SMALL_DOWN = REASON_W'(6);
  localparam logic [REASON_W-1:0] RSN_BIG_UP     = REASON_W'(7);
  localparam logic [REASON_W-1:0] RSN_SMALL_UP   = REASON_W'(8);

  typedef struct packed {
    logic [RPM_W-1:0]  engine_rpm;
    logic [TIME_W-1:0] now_ms;
    logic              cranking;
    logic              tps_present;
    logic [POS_W-1:0]  throttle_pos;
  } ivds_in_t;

  typedef struct packed {
    logic [DUTY_W-1:0]   duty;
    logic [REASON_W-1:0] reason;
  } ivds_out_t;

endpackage

[hdl/idle_valve_duty_stepper_unit.sv]
// Idle valve duty stepper: one control tick in, new valve duty and reason code out.
//
// Each input word is one control tick. It is caught in an input register, and once the
// output register is empty or being emptied, a single pass of compares, one add and a
// clamp decides the new duty, which lands in the output register together with the
// reason code while the duty and last-change-time state update at the same edge. A new
// word is accepted every cycle as long as the result side keeps up; the rate is set by
// the feedback of the duty state through that pass. The output register lets a new
// word enter while an earlier result is still waiting to be taken. The band edges,
// floor of 0.93 and 1.07 times the target speed, are worked out by constant
// multiplications when the target is written and are kept in registers, so the
// target register itself is not stored. Configuration is meant to be written only
// while the block is idle.
`include "idle_valve_duty_stepper_unit_assert.svh"

module idle_valve_duty_stepper_unit (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  ivds_pkg::ivds_in_t                   in_word,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output ivds_pkg::ivds_out_t                  out_word,
  input  logic                                 cfg_wr_en,
  input  logic [ivds_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [ivds_pkg::CFG_DATA_W-1:0]      cfg_wdata
);
  import ivds_pkg::*;

  // Configuration registers. The band edges replace the raw target speed.
  logic [RPM_W-1:0]  left_r, right_r;
  logic [DUTY_W-1:0] min_duty_r, max_duty_r;
  logic [DUTY_W-1:0] big_dec_r, small_dec_r, big_inc_r, small_inc_r;

  // Block state.
  logic [DUTY_W-1:0] valve_duty_r;
  logic [TIME_W-1:0] last_change_r;

  // Handshake and payload registers.
  logic      in_vld_r, in_vld_nxt;
  logic      out_vld_r, out_vld_nxt;
  ivds_in_t  in_r;
  ivds_out_t out_r, out_nxt;

  logic accept_in;
  logic move;

  // Band edge computation from the written target.
  logic [PROD_W-1:0] left_prod, right_prod;
  logic [RPM_W-1:0]  left_nxt, right_nxt;

  // Decision logic.
  logic [RPM_W+3:0]        rpm_x10, left_x7;
  logic [TIME_W-1:0]       elapsed;
  logic [RPM_W:0]          right_plus;
  logic [RPM_W:0]          rpm_plus;
  logic                    stop_crank, far_low, settling, in_band, lockout;
  logic                    big_down, small_down, big_up;
  logic                    apply;
  logic [REASON_W-1:0]     reason;
  logic signed [DUTY_EXT_W-1:0] cur_s, want_s, raise_s, clamp_s;
  logic signed [DUTY_EXT_W-1:0] min_s, max_s;
  logic [DUTY_W-1:0]       duty_nxt;
  logic                    changed;

  // ---------------------------------------------------------------------------
  // Configuration port. A target write loads both band edges at once, so a tick
  // arriving right after the write already sees the new band.
  // ---------------------------------------------------------------------------
  assign left_prod  = PROD_W'(cfg_wdata[TARGET_W-1:0]) * PROD_W'(LEFT_MULT);
  assign right_prod = PROD_W'(cfg_wdata[TARGET_W-1:0]) * PROD_W'(RIGHT_MULT);
  assign left_nxt   = left_prod[RECIP_SHIFT +: RPM_W];
  assign right_nxt  = right_prod[RECIP_SHIFT +: RPM_W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r      <= LEFT_RST;
      right_r     <= RIGHT_RST;
      min_duty_r  <= MIN_DUTY_RST;
      max_duty_r  <= MAX_DUTY_RST;
      big_dec_r   <= BIG_STEP_RST;
      small_dec_r <= SMALL_STEP_RST;
      big_inc_r   <= BIG_STEP_RST;
      small_inc_r <= SMALL_STEP_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_TARGET_RPM: begin
          left_r  <= left_nxt;
          right_r <= right_nxt;
        end
        CFG_MIN_DUTY:            min_duty_r  <= cfg_wdata[DUTY_W-1:0];
        CFG_MAX_DUTY:            max_duty_r  <= cfg_wdata[DUTY_W-1:0];
        CFG_BIG_DECREASE_STEP:   big_dec_r   <= cfg_wdata[DUTY_W-1:0];
        CFG_SMALL_DECREASE_STEP: small_dec_r <= cfg_wdata[DUTY_W-1:0];
        CFG_BIG_INCREASE_STEP:   big_inc_r   <= cfg_wdata[DUTY_W-1:0];
        CFG_SMALL_INCREASE_STEP: small_inc_r <= cfg_wdata[DUTY_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Flow control. A word leaves the input register when the output register is
  // empty or being emptied; the input register refills in that same cycle.
  // ---------------------------------------------------------------------------
  assign move        = in_vld_r && (!out_vld_r || !out_stall);
  assign in_stall    = in_vld_r && !move;
  assign accept_in   = in_valid && !in_stall;
  assign in_vld_nxt  = accept_in || (in_vld_r && !move);
  assign out_vld_nxt = move || (out_vld_r && out_stall);

  // ---------------------------------------------------------------------------
  // Decision pass. The checks follow a fixed priority: stopped or cranking, far
  // below the band, settling, inside the band, throttle lockout, then a step.
  // ---------------------------------------------------------------------------
  assign rpm_x10    = (RPM_W + 4)'({in_r.engine_rpm, 3'b000})
                    + (RPM_W + 4)'({in_r.engine_rpm, 1'b0});
  assign left_x7    = (RPM_W + 4)'({left_r, 3'b000}) - (RPM_W + 4)'(left_r);
  assign elapsed    = in_r.now_ms - last_change_r;
  assign right_plus = (RPM_W + 1)'(right_r) + MARGIN_RPM;
  assign rpm_plus   = (RPM_W + 1)'(in_r.engine_rpm) + MARGIN_RPM;

  assign stop_crank = (in_r.engine_rpm == '0) || in_r.cranking;
  assign far_low    = rpm_x10 < left_x7;
  assign settling   = elapsed < SETTLE_MS;
  assign in_band    = (in_r.engine_rpm > left_r) && (in_r.engine_rpm < right_r);
  assign lockout    = !in_r.tps_present || (in_r.throttle_pos > LOCKOUT_POS);
  assign big_down   = (RPM_W + 1)'(in_r.engine_rpm) >= right_plus;
  assign small_down = in_r.engine_rpm >= right_r;
  // Below the lower edge by more than the margin; never true when the edge
  // itself is under the margin.
  assign big_up     = rpm_plus < (RPM_W + 1)'(left_r);

  assign cur_s = $signed({2'b00, valve_duty_r});
  assign min_s = $signed({2'b00, min_duty_r});
  assign max_s = $signed({2'b00, max_duty_r});

  always_comb begin
    apply  = 1'b1;
    reason = RSN_SMALL_UP;
    want_s = cur_s + $signed({2'b00, small_inc_r});
    if (stop_crank) begin
      reason = RSN_STOP_CRANK;
      want_s = $signed({2'b00, DEFAULT_DUTY});
    end else if (far_low) begin
      reason = RSN_FAR_LOW;
      want_s = $signed({2'b00, DEFAULT_DUTY});
    end else if (settling) begin
      apply  = 1'b0;
      reason = RSN_SETTLING;
    end else if (in_band) begin
      apply  = 1'b0;
      reason = RSN_IN_BAND;
    end else if (lockout) begin
      apply  = 1'b0;
      reason = RSN_LOCKOUT;
    end else if (big_down) begin
      reason = RSN_BIG_DOWN;
      want_s = cur_s - $signed({2'b00, big_dec_r});
    end else if (small_down) begin
      reason = RSN_SMALL_DOWN;
      want_s = cur_s - $signed({2'b00, small_dec_r});
    end else if (big_up) begin
      reason = RSN_BIG_UP;
      want_s = cur_s + $signed({2'b00, big_inc_r});
    end
  end

  // Raise to the minimum first, then cap at the maximum, so the maximum wins
  // when the two limits are crossed.
  assign raise_s  = (want_s < min_s) ? min_s : want_s;
  assign clamp_s  = (raise_s > max_s) ? max_s : raise_s;
  assign duty_nxt = apply ? clamp_s[DUTY_W-1:0] : valve_duty_r;
  assign changed  = apply && (clamp_s[DUTY_W-1:0] != valve_duty_r);

  assign out_nxt.duty   = duty_nxt;
  assign out_nxt.reason = reason;

  // ---------------------------------------------------------------------------
  // Registers.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r      <= 1'b0;
      out_vld_r     <= 1'b0;
      valve_duty_r  <= DEFAULT_DUTY;
      last_change_r <= '0;
    end else begin
      in_vld_r  <= in_vld_nxt;
      out_vld_r <= out_vld_nxt;
      if (move) begin
        valve_duty_r <= duty_nxt;
        if (changed) begin
          last_change_r <= in_r.now_ms;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept_in) begin
      in_r <= in_word;
    end
    if (move) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_vld_r;
  assign out_word  = out_r;

  // ---------------------------------------------------------------------------
  // Checks on the state update and the flow control.
  // ---------------------------------------------------------------------------
  `IVDS_ASSERT_NEXT(a_duty_holds_without_tick, !move, $stable(valve_duty_r),
    "valve duty changed without a tick being processed")
  `IVDS_ASSERT_NEXT(a_time_tracks_duty, move && !changed, $stable(last_change_r),
    "last change time moved although the duty did not change")
  `IVDS_ASSERT_IMPLY(a_result_matches_state, out_vld_r && $past(move),
    out_r.duty == valve_duty_r, "fresh result duty differs from the held duty")
  `IVDS_ASSERT_IMPLY(a_stall_only_when_full, in_stall, in_vld_r && out_vld_r && out_stall,
    "input stalled while a word could move on")

endmodule

[tb/idle_valve_duty_stepper_unit_tb.sv]
// Self-checking testbench of the idle valve duty stepper: directed rule and clamp ticks, then random ticks.
module idle_valve_duty_stepper_unit_tb;
  import ivds_pkg::*;

  // Reset values of the registers as the block comes out of reset.
  localparam int TARGET_RST = 1000;
  // Band edges are whole percentages of the target speed.
  localparam int BAND_LO_PCT = 93;
  localparam int BAND_HI_PCT = 107;
  // Far below the band means under seventy percent of the lower edge.
  localparam int FAR_LOW_NUM = 7;
  localparam int FAR_LOW_DEN = 10;
  localparam int TICKS_PER_SET = 150;
  localparam int SETS_PER_PHASE = 4;

  logic                         clk;
  logic                         rst_n;
  logic                         in_valid;
  logic                         in_stall;
  ivds_in_t                     in_word;
  logic                         out_valid;
  logic                         out_stall;
  ivds_out_t                    out_word;
  logic                         cfg_wr_en;
  logic [CFG_INDEX_W-1:0]       cfg_index;
  logic [CFG_DATA_W-1:0]        cfg_wdata;

  // Our own copy of the block's registers and state.
  logic [TARGET_W-1:0] tgt_rpm;
  logic [DUTY_W-1:0]   duty_floor;
  logic [DUTY_W-1:0]   duty_ceil;
  logic [DUTY_W-1:0]   down_big;
  logic [DUTY_W-1:0]   down_small;
  logic [DUTY_W-1:0]   up_big;
  logic [DUTY_W-1:0]   up_small;
  logic [DUTY_W-1:0]   duty_state;
  logic [TIME_W-1:0]   stamp_ms;

  // Duty and reason words still owed by the block, oldest first.
  ivds_out_t predicted_q[$];

  int          mismatches = 0;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  logic [31:0] now_cursor;

  idle_valve_duty_stepper_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // A hung handshake ends the run here.
  initial begin
    #4000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // The receiver stalls at random; the share is set per phase by the main sequence.
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  // Puts the predictor back to the state the block has after reset.
  task automatic reset_predictor();
    tgt_rpm    = TARGET_W'(TARGET_RST);
    duty_floor = MIN_DUTY_RST;
    duty_ceil  = MAX_DUTY_RST;
    down_big   = BIG_STEP_RST;
    down_small = SMALL_STEP_RST;
    up_big     = BIG_STEP_RST;
    up_small   = SMALL_STEP_RST;
    duty_state = DEFAULT_DUTY;
    stamp_ms   = '0;
  endtask

  // Works out the duty and reason for one tick and moves the predicted state on.
  function automatic ivds_out_t predict_tick(input ivds_in_t w);
    int                  rpm;
    int                  pos;
    int                  left;
    int                  right;
    int                  want;
    logic [TIME_W-1:0]   elapsed;
    logic [REASON_W-1:0] why;
    bit                  moves;
    ivds_out_t           r;
    rpm     = int'(w.engine_rpm);
    pos     = int'(w.throttle_pos);
    left    = int'(tgt_rpm) * BAND_LO_PCT / 100;
    right   = int'(tgt_rpm) * BAND_HI_PCT / 100;
    elapsed = w.now_ms - stamp_ms;
    moves   = 1'b1;
    want    = int'(DEFAULT_DUTY);
    if (rpm == 0 || w.cranking) begin
      why = RSN_STOP_CRANK;
    end else if (FAR_LOW_DEN * rpm < FAR_LOW_NUM * left) begin
      why = RSN_FAR_LOW;
    end else if (elapsed < SETTLE_MS) begin
      why   = RSN_SETTLING;
      moves = 1'b0;
    end else if (rpm > left && rpm < right) begin
      why   = RSN_IN_BAND;
      moves = 1'b0;
    end else if (!w.tps_present || pos > int'(LOCKOUT_POS)) begin
      why   = RSN_LOCKOUT;
      moves = 1'b0;
    end else if (rpm >= right + int'(MARGIN_RPM)) begin
      why  = RSN_BIG_DOWN;
      want = int'(duty_state) - int'(down_big);
    end else if (rpm >= right) begin
      why  = RSN_SMALL_DOWN;
      want = int'(duty_state) - int'(down_small);
    end else if (rpm < left - int'(MARGIN_RPM)) begin
      why  = RSN_BIG_UP;
      want = int'(duty_state) + int'(up_big);
    end else begin
      why  = RSN_SMALL_UP;
      want = int'(duty_state) + int'(up_small);
    end
    if (moves) begin
      // Floor first, then ceiling, so a floor above the ceiling gives the ceiling.
      if (want < int'(duty_floor)) want = int'(duty_floor);
      if (want > int'(duty_ceil)) want = int'(duty_ceil);
      if (want != int'(duty_state)) stamp_ms = w.now_ms;
      duty_state = DUTY_W'(want);
    end
    r.duty   = duty_state;
    r.reason = why;
    return r;
  endfunction

  // Offers one word to the block, with random idle cycles ahead of it, and records
  // the expected result once the word has been taken.
  task automatic send_tick(input ivds_in_t w);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predicted_q.push_back(predict_tick(w));
  endtask

  task automatic send_at(input int rpm, input logic [31:0] now, input bit crank,
                         input bit tps, input int pos);
    ivds_in_t w;
    w.engine_rpm   = RPM_W'(rpm);
    w.now_ms       = now;
    w.cranking     = crank;
    w.tps_present  = tps;
    w.throttle_pos = POS_W'(pos);
    send_tick(w);
  endtask

  // Stops sending and waits until every owed result is out and the block is quiet.
  task automatic settle_block();
    @(negedge clk);
    in_valid <= 1'b0;
    while (predicted_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input int unsigned val);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= CFG_DATA_W'(val);
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    case (idx)
      CFG_TARGET_RPM:          tgt_rpm    = val[TARGET_W-1:0];
      CFG_MIN_DUTY:            duty_floor = val[DUTY_W-1:0];
      CFG_MAX_DUTY:            duty_ceil  = val[DUTY_W-1:0];
      CFG_BIG_DECREASE_STEP:   down_big   = val[DUTY_W-1:0];
      CFG_SMALL_DECREASE_STEP: down_small = val[DUTY_W-1:0];
      CFG_BIG_INCREASE_STEP:   up_big     = val[DUTY_W-1:0];
      CFG_SMALL_INCREASE_STEP: up_small   = val[DUTY_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_settings(input int unsigned target, input int unsigned lo,
                              input int unsigned hi, input int unsigned dn_big,
                              input int unsigned dn_small, input int unsigned u_big,
                              input int unsigned u_small);
    write_reg(CFG_TARGET_RPM, target);
    write_reg(CFG_MIN_DUTY, lo);
    write_reg(CFG_MAX_DUTY, hi);
    write_reg(CFG_BIG_DECREASE_STEP, dn_big);
    write_reg(CFG_SMALL_DECREASE_STEP, dn_small);
    write_reg(CFG_BIG_INCREASE_STEP, u_big);
    write_reg(CFG_SMALL_INCREASE_STEP, u_small);
  endtask

  // Every decision branch with the reset settings (edges 930 and 1070), including the
  // band edges themselves, the far-low boundary and the settle window across the wrap.
  task automatic test_tick_rules();
    send_at(0,     32'd0,        1'b0, 1'b1, 0);    // stopped engine
    send_at(1000,  32'd500,      1'b1, 1'b1, 0);    // cranking
    send_at(1000,  32'd600,      1'b0, 1'b1, 0);    // still settling after reset
    send_at(1000,  32'd1200,     1'b0, 1'b1, 0);    // in band
    send_at(1200,  32'd1300,     1'b0, 1'b0, 0);    // no throttle sensor
    send_at(1200,  32'd1400,     1'b0, 1'b1, 51);   // throttle just past lockout
    send_at(1170,  32'd1500,     1'b0, 1'b1, 50);   // big down at the margin edge
    send_at(1169,  32'd2500,     1'b0, 1'b1, 0);    // small down
    send_at(1070,  32'd3500,     1'b0, 1'b1, 0);    // upper edge is outside the band
    send_at(829,   32'd4500,     1'b0, 1'b1, 0);    // big up
    send_at(830,   32'd5500,     1'b0, 1'b1, 0);    // small up
    send_at(930,   32'd6500,     1'b0, 1'b1, 0);    // lower edge is outside the band
    send_at(650,   32'd7500,     1'b0, 1'b1, 0);    // just far low
    send_at(651,   32'd7600,     1'b0, 1'b1, 0);    // just above far low
    send_at(651,   32'hFFFF_FF00, 1'b0, 1'b1, 0);
    send_at(651,   32'h0000_0100, 1'b0, 1'b1, 0);   // settle window spans the wrap
    send_at(16383, 32'hFFFF_FFFF, 1'b0, 1'b1, 1000);
  endtask

  // Clamping at both ends, a floor above the ceiling, zero steps and the target extremes.
  task automatic test_clamp_extremes();
    settle_block();
    set_settings(1000, 0, 1000, 1000, 0, 1000, 5);
    send_at(651,   32'h0001_0000, 1'b0, 1'b1, 0);   // clamps at the top
    send_at(2000,  32'h0001_1000, 1'b0, 1'b1, 0);   // clamps at zero
    send_at(2000,  32'h0001_2000, 1'b0, 1'b1, 0);   // negative sum, no change
    send_at(1070,  32'h0001_3000, 1'b0, 1'b1, 0);   // zero step holds the duty
    settle_block();
    set_settings(0, 800, 300, 20, 5, 20, 5);
    send_at(50,    32'h0001_4000, 1'b0, 1'b1, 0);   // floor above ceiling
    send_at(2000,  32'h0001_5000, 1'b0, 1'b1, 0);
    settle_block();
    set_settings(8191, 100, 900, 20, 5, 20, 5);
    send_at(5300,  32'h0001_6000, 1'b0, 1'b1, 0);
    send_at(16383, 32'h0001_7000, 1'b0, 1'b1, 0);
  endtask

  // Settings for one random stretch; extremes come up now and then.
  task automatic random_settings();
    int unsigned target;
    int unsigned lo;
    int unsigned hi;
    int unsigned swap;
    case ($urandom_range(9))
      0:       target = 0;
      1:       target = 8191;
      default: target = $urandom_range(4000, 300);
    endcase
    lo = $urandom_range(300);
    hi = $urandom_range(1000, 500);
    if ($urandom_range(9) == 0) begin
      swap = lo;
      lo   = hi;
      hi   = swap;
    end
    set_settings(target, lo, hi,
                 ($urandom_range(9) == 0) ? $urandom_range(1000) : $urandom_range(60),
                 ($urandom_range(9) == 0) ? $urandom_range(1000) : $urandom_range(60),
                 ($urandom_range(9) == 0) ? $urandom_range(1000) : $urandom_range(60),
                 ($urandom_range(9) == 0) ? $urandom_range(1000) : $urandom_range(60));
  endtask

  // Most ticks sit near the band edges with a steadily running clock, so the settle
  // window, lockout and every step branch keep coming up; a few are pure noise.
  function automatic ivds_in_t random_tick();
    ivds_in_t w;
    int       left;
    int       right;
    int       centre;
    int       lo;
    int       hi;
    int       pick;
    left  = int'(tgt_rpm) * BAND_LO_PCT / 100;
    right = int'(tgt_rpm) * BAND_HI_PCT / 100;
    pick  = $urandom_range(99);
    if (pick < 4) begin
      w.engine_rpm = '0;
    end else if (pick < 12) begin
      w.engine_rpm = RPM_W'($urandom);
    end else if (pick < 22) begin
      w.engine_rpm = RPM_W'($urandom_range(left * FAR_LOW_NUM / FAR_LOW_DEN + 1));
    end else begin
      centre = $urandom_range(1) ? left : right;
      lo = (centre - 250 < 1) ? 1 : centre - 250;
      hi = (centre + 250 > 16383) ? 16383 : centre + 250;
      w.engine_rpm = RPM_W'($urandom_range(hi, lo));
    end
    pick = $urandom_range(99);
    if (pick < 4) now_cursor = $urandom;
    else if (pick < 30) now_cursor = now_cursor + $urandom_range(999);
    else now_cursor = now_cursor + $urandom_range(3000, 1000);
    w.now_ms       = now_cursor;
    w.cranking     = ($urandom_range(99) < 5);
    w.tps_present  = ($urandom_range(99) < 90);
    w.throttle_pos = ($urandom_range(99) < 75) ? POS_W'($urandom_range(70))
                                               : POS_W'($urandom_range(1000));
    return w;
  endfunction

  task automatic test_random_ticks(input int send_pct, input int recv_pct);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    repeat (SETS_PER_PHASE) begin
      settle_block();
      random_settings();
      repeat (TICKS_PER_SET) send_tick(random_tick());
    end
  endtask

  // Each accepted result is held against the oldest owed one, field by field.
  always @(posedge clk) begin
    ivds_out_t exp_word;
    if (rst_n && out_valid && !out_stall) begin
      if (predicted_q.size() == 0) begin
        $error("result word with nothing owed: duty %0d reason %0d",
               out_word.duty, out_word.reason);
        mismatches++;
      end else begin
        exp_word = predicted_q.pop_front();
        if (out_word.duty !== exp_word.duty) begin
          $error("duty: expected %0d, actual %0d", exp_word.duty, out_word.duty);
          mismatches++;
        end
        if (out_word.reason !== exp_word.reason) begin
          $error("reason: expected %0d, actual %0d", exp_word.reason, out_word.reason);
          mismatches++;
        end
      end
    end
  end

  initial begin
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_word   = '0;
    out_stall = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    reset_predictor();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part runs under the first idling pattern.
    send_idle_pct = 14;
    recv_idle_pct = 87;
    test_tick_rules();
    test_clamp_extremes();

    now_cursor = $urandom;
    test_random_ticks(14, 87);
    test_random_ticks(87, 14);
    test_random_ticks(0, 0);

    settle_block();
    repeat (10) @(posedge clk);
    if (predicted_q.size() != 0) begin
      $error("%0d result words never arrived", predicted_q.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+hdl
hdl/ivds_pkg.sv
hdl/idle_valve_duty_stepper_unit.sv
tb/idle_valve_duty_stepper_unit_tb.sv
